/* rtl/core/tri_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tri_pkg
// Shared types, status codes and width helpers for the trilateration core.
// ----------------------------------------------------------------------------
package tri_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int Q_BITS         = 32;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_DIST = 2'd1;
	localparam logic [1:0] ST_COLLINEAR = 2'd2;
	localparam logic [1:0] ST_SATURATED = 2'd3;

	typedef struct packed {
		logic        [15:0] dist_a;
		logic        [15:0] dist_b;
		logic        [15:0] dist_c;
		logic signed [15:0] anchor_a_x;
		logic signed [15:0] anchor_a_y;
		logic signed [15:0] anchor_b_x;
		logic signed [15:0] anchor_b_y;
		logic signed [15:0] anchor_c_x;
		logic signed [15:0] anchor_c_y;
	} meas_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [1:0]  status;
	} fix_t;

	// per-fix flags that ride alongside the quotient datapath
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic zero_dist;
		logic collinear;
	} flags_t;

	// k = d^2 - x^2 - y^2 width (signed)
	function automatic int k_w(input int c);
		return ((2 * c > 33) ? 2 * c : 33) + 2;
	endfunction

	// numerator magnitude width
	function automatic int num_w(input int c);
		return k_w(c) + c + 1 + 2;
	endfunction

	// determinant width (signed); 2|D| also fits here unsigned
	function automatic int den_w(input int c);
		return 2 * c + 3;
	endfunction

endpackage

/* rtl/core/tri_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tri_front
// Six-stage front end: squares, k terms, determinant and the two numerators,
// ending in magnitudes, signs and the 2|D| divisor.
// ----------------------------------------------------------------------------
module tri_front #(
	parameter int COORD_BITS = tri_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  tri_pkg::meas_t                         meas,
	output logic                                   out_valid,
	output logic [tri_pkg::num_w(COORD_BITS)-1:0] num_x,
	output logic [tri_pkg::num_w(COORD_BITS)-1:0] num_y,
	output logic [tri_pkg::den_w(COORD_BITS)-1:0] den,
	output tri_pkg::flags_t                        flags
);
	import tri_pkg::*;

	localparam int XW  = COORD_BITS;
	localparam int DFW = XW + 1;
	localparam int SQW = 2 * XW;
	localparam int KW  = k_w(XW);
	localparam int PW  = KW + DFW;
	localparam int NW  = num_w(XW);
	localparam int DTW = den_w(XW);

	// low COORD_BITS of the field, sign-extended; wider settings see the
	// 16-bit field as a non-negative value
	function automatic logic signed [XW-1:0] coord(input logic [15:0] raw);
		logic [XW-1:0] v;
		v = XW'(raw);
		return $signed(v);
	endfunction

	logic [5:0] vld;

	logic        [15:0]   d_s1 [3];
	logic signed [XW-1:0] x_s1 [3];
	logic signed [XW-1:0] y_s1 [3];
	logic                 z_s1;

	logic        [31:0]    d2_s2 [3];
	logic signed [SQW-1:0] x2_s2 [3];
	logic signed [SQW-1:0] y2_s2 [3];
	logic signed [XW-1:0]  x_s2  [3];
	logic signed [DFW-1:0] dy_s2 [3];
	logic signed [DFW-1:0] dx_s2 [3];
	logic                  z_s2;

	logic signed [KW-1:0]     k_s3   [3];
	logic signed [XW+DFW-1:0] dtp_s3 [3];
	logic signed [DFW-1:0]    dy_s3  [3];
	logic signed [DFW-1:0]    dx_s3  [3];
	logic                     z_s3;

	logic signed [PW-1:0]  px_s4 [3];
	logic signed [PW-1:0]  py_s4 [3];
	logic signed [DTW-1:0] det_s4;
	logic                  z_s4;

	logic signed [NW-1:0]  nx_s5;
	logic signed [NW-1:0]  ny_s5;
	logic signed [DTW-1:0] det_s5;
	logic                  z_s5;

	logic [NW-1:0]  anx_s6;
	logic [NW-1:0]  any_s6;
	logic [DTW-1:0] den_s6;
	flags_t         fl_s6;

	logic [DTW-1:0] adet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[4:0], in_valid};
		end
	end

	assign adet = det_s5[DTW-1] ? DTW'(-det_s5) : DTW'(det_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: capture
			d_s1[0] <= meas.dist_a;
			d_s1[1] <= meas.dist_b;
			d_s1[2] <= meas.dist_c;
			x_s1[0] <= coord(meas.anchor_a_x);
			y_s1[0] <= coord(meas.anchor_a_y);
			x_s1[1] <= coord(meas.anchor_b_x);
			y_s1[1] <= coord(meas.anchor_b_y);
			x_s1[2] <= coord(meas.anchor_c_x);
			y_s1[2] <= coord(meas.anchor_c_y);
			z_s1    <= (meas.dist_a == '0) || (meas.dist_b == '0) || (meas.dist_c == '0);

			// s2: squares and cyclic differences
			for (int i = 0; i < 3; i++) begin
				d2_s2[i] <= 32'(d_s1[i]) * 32'(d_s1[i]);
				x2_s2[i] <= SQW'(x_s1[i]) * SQW'(x_s1[i]);
				y2_s2[i] <= SQW'(y_s1[i]) * SQW'(y_s1[i]);
				x_s2[i]  <= x_s1[i];
				dy_s2[i] <= DFW'(y_s1[(i+1)%3]) - DFW'(y_s1[(i+2)%3]);
				dx_s2[i] <= DFW'(x_s1[(i+1)%3]) - DFW'(x_s1[(i+2)%3]);
			end
			z_s2 <= z_s1;

			// s3: k terms and determinant products
			for (int i = 0; i < 3; i++) begin
				k_s3[i]   <= KW'($signed({1'b0, d2_s2[i]})) - KW'(x2_s2[i]) - KW'(y2_s2[i]);
				dtp_s3[i] <= (XW+DFW)'(x_s2[i]) * (XW+DFW)'(dy_s2[i]);
				dy_s3[i]  <= dy_s2[i];
				dx_s3[i]  <= dx_s2[i];
			end
			z_s3 <= z_s2;

			// s4: numerator products, determinant sum
			for (int i = 0; i < 3; i++) begin
				px_s4[i] <= PW'(k_s3[i]) * PW'(dy_s3[i]);
				py_s4[i] <= PW'(k_s3[i]) * PW'(dx_s3[i]);
			end
			det_s4 <= DTW'(dtp_s3[0]) + DTW'(dtp_s3[1]) + DTW'(dtp_s3[2]);
			z_s4   <= z_s3;

			// s5: numerator sums
			nx_s5  <= NW'(px_s4[0]) + NW'(px_s4[1]) + NW'(px_s4[2]);
			ny_s5  <= NW'(py_s4[0]) + NW'(py_s4[1]) + NW'(py_s4[2]);
			det_s5 <= det_s4;
			z_s5   <= z_s4;

			// s6: magnitudes and signs; x carries the extra negation
			anx_s6          <= nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
			any_s6          <= ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
			den_s6          <= DTW'({adet[DTW-2:0], 1'b0});
			fl_s6.neg_x     <= !(nx_s5[NW-1] ^ det_s5[DTW-1]);
			fl_s6.neg_y     <= ny_s5[NW-1] ^ det_s5[DTW-1];
			fl_s6.zero_dist <= z_s5;
			fl_s6.collinear <= (det_s5 == '0);
		end
	end

	assign out_valid = vld[5];
	assign num_x     = anx_s6;
	assign num_y     = any_s6;
	assign den       = den_s6;
	assign flags     = fl_s6;

endmodule

/* rtl/core/tri_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tri_div
// Pipelined restoring divider: one range-check stage, then one quotient bit
// per stage for a 32-bit unsigned quotient.
// ----------------------------------------------------------------------------
module tri_div #(
	parameter int NW  = 64,
	parameter int DW  = 40,
	parameter int SBW = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [NW-1:0]              num,
	input  logic [DW-1:0]              den,
	input  logic [SBW-1:0]             sb_in,
	output logic                       out_valid,
	output logic [tri_pkg::Q_BITS-1:0] quo,
	output logic                       ovf,
	output logic [SBW-1:0]             sb_out
);
	import tri_pkg::*;

	localparam int CW = NW + Q_BITS + 1;

	logic [NW-1:0]     r_s   [Q_BITS+1];
	logic [DW-1:0]     d_s   [Q_BITS+1];
	logic [Q_BITS-1:0] q_s   [Q_BITS+1];
	logic              ov_s  [Q_BITS+1];
	logic [SBW-1:0]    sb_s  [Q_BITS+1];
	logic [Q_BITS:0]   vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[Q_BITS-1:0], in_valid};
		end
	end

	// quotient would need more than 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]  <= num;
			d_s[0]  <= den;
			q_s[0]  <= '0;
			ov_s[0] <= CW'(num) >= (CW'(den) << Q_BITS);
			sb_s[0] <= sb_in;
		end
	end

	for (genvar i = 1; i <= Q_BITS; i++) begin : g_step
		logic [CW-1:0] sh;
		logic          ge;
		assign sh = CW'(d_s[i-1]) << (Q_BITS - i);
		assign ge = CW'(r_s[i-1]) >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i]  <= ge ? NW'(CW'(r_s[i-1]) - sh) : r_s[i-1];
				d_s[i]  <= d_s[i-1];
				q_s[i]  <= {q_s[i-1][Q_BITS-2:0], ge};
				ov_s[i] <= ov_s[i-1];
				sb_s[i] <= sb_s[i-1];
			end
		end
	end

	assign out_valid = vld[Q_BITS];
	assign quo       = q_s[Q_BITS];
	assign ovf       = ov_s[Q_BITS];
	assign sb_out    = sb_s[Q_BITS];

endmodule

/* rtl/core/trilateration_three_anchors.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilateration_three_anchors
// Closed-form 2-D position fix from three anchors and three distances.
// ----------------------------------------------------------------------------
// One measurement beat in, one fix beat out, in order. The core is a fully
// pipelined datapath that takes a new beat every cycle unless the output
// register is stalled; a beat passes through six arithmetic stages (capture,
// squares, k terms, products, sums, magnitudes), one divider range check,
// 32 restoring-divider stages (one quotient bit each, x and y in parallel
// units) and the output register. The whole pipe advances together whenever
// the output register is empty or being drained, so meas_ready follows
// fix_ready combinationally. pos_x = -Nx/(2D), pos_y = Ny/(2D), truncated
// toward zero. status: ok, zero distance (checked first), collinear anchors
// (D zero), or saturated (either coordinate clamped to 32 bits). Position is
// zero for the two error codes.
// ----------------------------------------------------------------------------
module trilateration_three_anchors #(
	parameter int COORD_BITS = tri_pkg::COORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           meas_valid,
	output logic           meas_ready,
	input  tri_pkg::meas_t meas,
	output logic           fix_valid,
	input  logic           fix_ready,
	output tri_pkg::fix_t  fix
);
	import tri_pkg::*;

	localparam int NW  = num_w(COORD_BITS);
	localparam int DW  = den_w(COORD_BITS);
	localparam int SBW = $bits(flags_t);

	logic           en;
	logic           fe_valid;
	logic [NW-1:0]  num_x;
	logic [NW-1:0]  num_y;
	logic [DW-1:0]  den;
	flags_t         fe_flags;

	logic              vx;
	logic              vy;
	logic [Q_BITS-1:0] qx;
	logic [Q_BITS-1:0] qy;
	logic              ovx;
	logic              ovy;
	logic [SBW-1:0]    sbx;
	logic [SBW-1:0]    sby;
	flags_t            fl;

	logic              sat_x;
	logic              sat_y;
	logic signed [31:0] px;
	logic signed [31:0] py;
	fix_t              nxt;

	logic fix_vld_q;
	fix_t fix_q;

	// whole pipe moves when the output slot frees
	assign en         = !fix_vld_q || fix_ready;
	assign meas_ready = en;

	tri_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (meas_valid),
		.meas     (meas),
		.out_valid(fe_valid),
		.num_x    (num_x),
		.num_y    (num_y),
		.den      (den),
		.flags    (fe_flags)
	);

	tri_div #(.NW(NW), .DW(DW), .SBW(SBW)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fe_valid),
		.num      (num_x),
		.den      (den),
		.sb_in    (fe_flags),
		.out_valid(vx),
		.quo      (qx),
		.ovf      (ovx),
		.sb_out   (sbx)
	);

	tri_div #(.NW(NW), .DW(DW), .SBW(SBW)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fe_valid),
		.num      (num_y),
		.den      (den),
		.sb_in    (fe_flags),
		.out_valid(vy),
		.quo      (qy),
		.ovf      (ovy),
		.sb_out   (sby)
	);

	assign fl = flags_t'(sbx);

	// sign and clamp: negative side reaches -2^31, positive side 2^31-1
	always_comb begin
		if (fl.neg_x) begin
			sat_x = ovx || (qx > 32'h8000_0000);
			px    = sat_x ? 32'sh8000_0000 : $signed(32'(-qx));
		end else begin
			sat_x = ovx || qx[31];
			px    = sat_x ? 32'sh7FFF_FFFF : $signed(qx);
		end
		if (fl.neg_y) begin
			sat_y = ovy || (qy > 32'h8000_0000);
			py    = sat_y ? 32'sh8000_0000 : $signed(32'(-qy));
		end else begin
			sat_y = ovy || qy[31];
			py    = sat_y ? 32'sh7FFF_FFFF : $signed(qy);
		end

		nxt.pos_x  = px;
		nxt.pos_y  = py;
		nxt.status = ST_OK;
		if (fl.zero_dist) begin
			nxt.pos_x  = '0;
			nxt.pos_y  = '0;
			nxt.status = ST_ZERO_DIST;
		end else if (fl.collinear) begin
			nxt.pos_x  = '0;
			nxt.pos_y  = '0;
			nxt.status = ST_COLLINEAR;
		end else if (sat_x || sat_y) begin
			nxt.status = ST_SATURATED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_vld_q <= 1'b0;
		end else if (en) begin
			fix_vld_q <= vx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fix_q <= nxt;
		end
	end

	assign fix_valid = fix_vld_q;
	assign fix       = fix_q;

	// both divider lanes march in lockstep; sidebands compared on live beats
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vx == vy && (!vx || sbx == sby))
		else $error("divider lanes out of step");

	// error codes carry a zero position
	a_err_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		fix_valid && (fix.status == ST_ZERO_DIST || fix.status == ST_COLLINEAR)
		|-> fix.pos_x == '0 && fix.pos_y == '0)
		else $error("error fix with nonzero position");

	// saturated status means one coordinate sits on a clamp value
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		fix_valid && fix.status == ST_SATURATED
		|-> fix.pos_x == 32'sh7FFF_FFFF || fix.pos_x == 32'sh8000_0000 ||
			fix.pos_y == 32'sh7FFF_FFFF || fix.pos_y == 32'sh8000_0000)
		else $error("saturated status without clamped coordinate");

	// a held fix beat keeps its payload while the pipe is frozen
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		fix_valid && !fix_ready |=> fix_valid && $stable(fix) && !$past(meas_ready))
		else $error("pipe advanced under backpressure");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the three-anchor trilateration core against an exact integer
// predictor: directed edge cases, then random fixes under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import tri_pkg::*;

	localparam int CB = COORD_BITS_DEF;

	logic  clk;
	logic  arst_n;
	logic  meas_valid;
	logic  meas_ready;
	meas_t meas;
	logic  fix_valid;
	logic  fix_ready;
	fix_t  fix;

	trilateration_three_anchors dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.meas_ready (meas_ready),
		.meas       (meas),
		.fix_valid  (fix_valid),
		.fix_ready  (fix_ready),
		.fix        (fix)
	);

	fix_t expected_fixes[$];
	int   mismatches;
	int   fixes_seen;
	int   beats_sent;
	int   send_idle_pct;
	int   stall_pct;
	int   status_seen[4];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sign-extend the low CB bits of a coordinate
	function automatic longint coord(input logic [15:0] raw);
		logic [15:0] t;
		t = raw << (16 - CB);
		return longint'($signed(t)) >>> (16 - CB);
	endfunction

	// truncating quotient of exact numerator by den, clamped to 32 bits
	function automatic logic signed [31:0] clamp_div(input logic signed [127:0] num,
			input logic signed [127:0] den, inout logic sat);
		logic signed [127:0] q;
		q = num / den;
		if (q > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (q < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return q[31:0];
	endfunction

	function automatic fix_t locate(input meas_t m);
		fix_t                r;
		longint              d[3], x[3], y[3];
		logic signed [127:0] k[3], det, nx, ny;
		logic                sat;
		d[0] = m.dist_a; d[1] = m.dist_b; d[2] = m.dist_c;
		x[0] = coord(m.anchor_a_x); y[0] = coord(m.anchor_a_y);
		x[1] = coord(m.anchor_b_x); y[1] = coord(m.anchor_b_y);
		x[2] = coord(m.anchor_c_x); y[2] = coord(m.anchor_c_y);
		r = '0;
		sat = 1'b0;
		if (d[0] == 0 || d[1] == 0 || d[2] == 0) begin
			r.status = ST_ZERO_DIST;
			return r;
		end
		det = 0; nx = 0; ny = 0;
		for (int i = 0; i < 3; i++) begin
			k[i] = d[i] * d[i] - x[i] * x[i] - y[i] * y[i];
			det += x[i] * (y[(i + 1) % 3] - y[(i + 2) % 3]);
		end
		if (det == 0) begin
			r.status = ST_COLLINEAR;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			nx += k[i] * (y[(i + 1) % 3] - y[(i + 2) % 3]);
			ny += k[i] * (x[(i + 1) % 3] - x[(i + 2) % 3]);
		end
		r.pos_x = clamp_div(-nx, 2 * det, sat);
		r.pos_y = clamp_div(ny, 2 * det, sat);
		r.status = sat ? ST_SATURATED : ST_OK;
		return r;
	endfunction

	// one measurement beat; prediction made at acceptance. Valid drops only
	// on idle cycles, so back-to-back beats keep it high.
	task automatic send_meas(input meas_t m);
		while ($urandom_range(99) < send_idle_pct) begin
			meas_valid <= 1'b0;
			@(posedge clk);
		end
		meas_valid <= 1'b1;
		meas <= m;
		do @(posedge clk); while (!meas_ready);
		expected_fixes.push_back(locate(m));
		beats_sent++;
	endtask

	task automatic drain();
		meas_valid <= 1'b0;
		while (expected_fixes.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		fix_ready <= ($urandom_range(99) >= stall_pct);
	end

	// fix checker
	always @(posedge clk) begin
		fix_t e;
		if (arst_n && fix_valid && fix_ready) begin
			fixes_seen++;
			if (expected_fixes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected fix beat %h", fix);
			end else begin
				e = expected_fixes.pop_front();
				status_seen[e.status]++;
				if (fix.pos_x !== e.pos_x || fix.pos_y !== e.pos_y
						|| fix.status !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("fix %0d: exp x=%0d y=%0d st=%0d got x=%0d y=%0d st=%0d",
							fixes_seen, e.pos_x, e.pos_y, e.status,
							fix.pos_x, fix.pos_y, fix.status);
				end
			end
		end
	end

	function automatic meas_t rand_meas(input int span);
		meas_t m;
		m = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
		if (span < 32768) begin
			m.anchor_a_x = $signed(16'($urandom_range(2 * span))) - 16'(span);
			m.anchor_a_y = $signed(16'($urandom_range(2 * span))) - 16'(span);
			m.anchor_b_x = $signed(16'($urandom_range(2 * span))) - 16'(span);
			m.anchor_b_y = $signed(16'($urandom_range(2 * span))) - 16'(span);
			m.anchor_c_x = $signed(16'($urandom_range(2 * span))) - 16'(span);
			m.anchor_c_y = $signed(16'($urandom_range(2 * span))) - 16'(span);
			m.dist_a = 16'($urandom_range(1, 2 * span + 1));
			m.dist_b = 16'($urandom_range(1, 2 * span + 1));
			m.dist_c = 16'($urandom_range(1, 2 * span + 1));
		end
		return m;
	endfunction

	task automatic test_directed();
		meas_t m;
		// plain triangle, fix near (3750,4312)
		m = '{5000, 7071, 4472, 0, 0, 10000, 0, 0, 8000};
		send_meas(m);
		// zero distance on each anchor
		m.dist_a = 0; send_meas(m);
		m.dist_a = 5000; m.dist_b = 0; send_meas(m);
		m.dist_b = 7071; m.dist_c = 0; send_meas(m);
		// collinear anchors
		send_meas('{100, 200, 300, 0, 0, 10, 10, -20, -20});
		send_meas('{1, 1, 1, 5, 5, 5, 5, 5, 5});
		// coordinate extremes, max distances
		send_meas('{16'hFFFF, 16'hFFFF, 16'hFFFF, -32768, -32768, 32767, -32768,
			-32768, 32767});
		send_meas('{16'hFFFF, 1, 16'hFFFF, 32767, 32767, -32768, 32767, 32767, -32768});
		// tiny determinant, huge numerator: results near the clamp, both signs
		send_meas('{16'hFFFF, 1, 1, 0, 0, 1, 0, 0, 1});
		send_meas('{1, 16'hFFFF, 16'hFFFF, 0, 0, 1, 0, 0, 1});
		send_meas('{1, 16'hFFFF, 1, 0, 0, -1, 0, 0, -1});
		send_meas('{1, 1, 1, 0, 0, 1, 0, 0, 1});
		send_meas('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_meas('{16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h5555, 16'h0001,
			16'h8000, 16'h7FFF, 16'hFFFE});
	endtask

	task automatic test_random(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: send_meas(rand_meas(32768));
				1, 2: send_meas(rand_meas(4));
				default: send_meas(rand_meas($urandom_range(8, 20000)));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		meas_valid = 1'b0;
		meas = '0;
		fix_ready = 1'b0;
		mismatches = 0;
		fixes_seen = 0;
		beats_sent = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();  // sender holds off until the pipe is empty
		test_random(110, 0, 0);
		test_random(110, 78, 0);
		test_random(110, 0, 78);
		test_random(110, 30, 30);
		drain();
		$display("sent %0d measurement beats, checked %0d fixes", beats_sent, fixes_seen);
		$display("status mix: ok %0d, zero dist %0d, collinear %0d, saturated %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0 && expected_fixes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
